// ----- rtl/core/smac_pkg.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker package
// Shared widths, codes, payload words and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int BLOCK_SHIFT          = 3;
    localparam int BLOCK_MASK           = (1 << BLOCK_SHIFT) - 1;
    localparam int DEF_SHADOW_ENTRIES   = 4096;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 13;
    localparam int LEN_W    = 16;
    localparam int CODE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int NBLK_W   = LEN_W - BLOCK_SHIFT;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKING_ENABLED = 1'd1;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_MARK  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_VIOLATION = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd2;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] access_size;
        logic              is_read;
        logic [LEN_W-1:0]  valid_bytes;
        logic [LEN_W-1:0]  total_bytes;
        logic [CODE_W-1:0] poison_code;
    } smac_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   redzone_code;
        logic                access_was_read;
    } smac_out_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic setup1;
        logic setup2;
        logic check_step;
        logic mark_step;
        logic out_load;
    } smac_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_mark;
        logic check_skip;
        logic mark_skip;
        logic check_done;
        logic mark_last;
    } smac_stat_t;

endpackage

// ----- rtl/core/smac_datapath.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker datapath
// Shadow store, configuration registers, range setup and walk counters.
// ----------------------------------------------------------------------------
module smac_datapath import smac_pkg::*; #(
    parameter int SHADOW_ENTRIES = DEF_SHADOW_ENTRIES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  smac_in_t              in_word,
    input  smac_cmd_t             cmd,
    output smac_stat_t            stat,
    output smac_out_t             out_word
);

    localparam int IDX_W        = $clog2(SHADOW_ENTRIES);
    localparam int RB_W         = IDX_W + BLOCK_SHIFT;
    localparam int LR_W         = ((RB_W > SIZE_W) ? RB_W : SIZE_W) + 1;
    localparam int S_W          = ((IDX_W > NBLK_W) ? IDX_W : NBLK_W) + 1;
    localparam int REGION_BYTES = SHADOW_ENTRIES << BLOCK_SHIFT;

    logic [CODE_W-1:0] mem [SHADOW_ENTRIES];

    logic [ADDR_W-1:0] base_reg;
    logic              en_reg;
    smac_in_t          in_reg;
    logic [ADDR_W:0]   rel_reg;
    smac_out_t         res_reg;
    smac_out_t         out_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  last_idx_reg;
    logic [BLOCK_SHIFT-1:0] off_hi_reg;
    logic              pend_valid_reg;
    logic              pend_last_reg;
    logic              issued_all_reg;
    logic [CODE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [NBLK_W-1:0] k_reg;
    logic [NBLK_W-1:0] nblk_reg;

    logic              in_region;
    logic [IDX_W-1:0]  start_idx;
    logic [NBLK_W-1:0] nblk;
    logic [LR_W-1:0]   last_rel;
    logic              clip;
    logic [S_W-1:0]    mark_end;
    logic              mark_reject;
    logic              issue;
    logic [BLOCK_SHIFT-1:0] hi;
    logic              fail;
    logic [NBLK_W-1:0] nvalid;
    logic [CODE_W-1:0] mark_value;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CODE_W-1:0] wr_data;

    assign in_region = rel_reg < (ADDR_W + 1)'(REGION_BYTES);
    assign start_idx = rel_reg[RB_W-1:BLOCK_SHIFT];
    assign nblk      = in_reg.total_bytes[LEN_W-1:BLOCK_SHIFT];
    assign last_rel  = LR_W'(rel_reg[RB_W-1:0]) + LR_W'(in_reg.access_size) - LR_W'(1);
    assign clip      = last_rel >= LR_W'(REGION_BYTES);
    assign mark_end  = S_W'(start_idx) + S_W'(nblk);

    assign mark_reject = (in_reg.address[BLOCK_SHIFT-1:0] != '0)
                      || (in_reg.total_bytes[BLOCK_SHIFT-1:0] != '0)
                      || (in_reg.valid_bytes > in_reg.total_bytes)
                      || !in_region
                      || (mark_end > S_W'(SHADOW_ENTRIES));

    assign issue = cmd.check_step && !issued_all_reg;
    assign hi    = pend_last_reg ? off_hi_reg : BLOCK_SHIFT'(BLOCK_MASK);
    assign fail  = (rd_data_reg != '0)
                && (rd_data_reg[CODE_W-1] || (CODE_W'(hi) >= rd_data_reg));

    assign nvalid = in_reg.valid_bytes[LEN_W-1:BLOCK_SHIFT];

    always_comb begin
        if (k_reg < nvalid) begin
            mark_value = '0;
        end else if ((k_reg == nvalid) && (in_reg.valid_bytes[BLOCK_SHIFT-1:0] != '0)) begin
            mark_value = CODE_W'(in_reg.valid_bytes[BLOCK_SHIFT-1:0]);
        end else begin
            mark_value = in_reg.poison_code;
        end
    end

    assign wr_en   = cmd.clear || cmd.mark_step;
    assign wr_addr = cmd.clear ? clr_idx_reg : wr_idx_reg;
    assign wr_data = cmd.clear ? '0 : mark_value;

    assign stat.clear_done = clr_idx_reg == IDX_W'(SHADOW_ENTRIES - 1);
    assign stat.is_mark    = in_reg.command == CMD_MARK;
    assign stat.check_skip = !en_reg || !in_region || (in_reg.access_size == '0);
    assign stat.mark_skip  = mark_reject || (nblk == '0);
    assign stat.check_done = pend_valid_reg && (fail || pend_last_reg);
    assign stat.mark_last  = (NBLK_W + 1)'(k_reg) + (NBLK_W + 1)'(1)
                          == (NBLK_W + 1)'(nblk_reg);

    assign out_word = out_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            en_reg         <= 1'b0;
            clr_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            issued_all_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    CFG_REGION_BASE:      base_reg <= cfg_wdata;
                    CFG_CHECKING_ENABLED: en_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.setup2) begin
                pend_valid_reg <= 1'b0;
                issued_all_reg <= 1'b0;
            end else if (cmd.check_step) begin
                pend_valid_reg <= issue;
                if (issue && (rd_idx_reg == last_idx_reg)) begin
                    issued_all_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= in_word;
        end
        if (cmd.setup1) begin
            rel_reg <= {1'b0, in_reg.address}
                     - {1'b0, base_reg[ADDR_W-1:BLOCK_SHIFT], BLOCK_SHIFT'(0)};
        end
        if (cmd.setup2) begin
            rd_idx_reg   <= start_idx;
            wr_idx_reg   <= start_idx;
            last_idx_reg <= clip ? IDX_W'(SHADOW_ENTRIES - 1) : last_rel[RB_W-1:BLOCK_SHIFT];
            off_hi_reg   <= clip ? BLOCK_SHIFT'(BLOCK_MASK) : last_rel[BLOCK_SHIFT-1:0];
            k_reg        <= '0;
            nblk_reg     <= nblk;
            if (in_reg.command == CMD_MARK) begin
                res_reg.status          <= mark_reject ? STATUS_REJECTED : STATUS_OK;
                res_reg.redzone_code    <= '0;
                res_reg.access_was_read <= 1'b0;
            end else begin
                res_reg.status          <= STATUS_OK;
                res_reg.redzone_code    <= '0;
                res_reg.access_was_read <= in_reg.is_read;
            end
        end
        if (issue) begin
            rd_idx_reg    <= rd_idx_reg + IDX_W'(1);
            pend_last_reg <= rd_idx_reg == last_idx_reg;
        end
        if (cmd.check_step && pend_valid_reg && fail) begin
            res_reg.status       <= STATUS_VIOLATION;
            res_reg.redzone_code <= rd_data_reg;
        end
        if (cmd.mark_step) begin
            wr_idx_reg <= wr_idx_reg + IDX_W'(1);
            k_reg      <= k_reg + NBLK_W'(1);
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ((IDX_W + 1)'(wr_addr) < (IDX_W + 1)'(SHADOW_ENTRIES)))
        else $error("shadow write outside the store");

    a_rd_not_past_last: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (rd_idx_reg <= last_idx_reg))
        else $error("check walk read past its last block");
`endif

endmodule

// ----- rtl/core/smac_ctrl.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker controller
// Sequences the clearing pass, setup, check and mark walks and the response.
// ----------------------------------------------------------------------------
module smac_ctrl import smac_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  smac_stat_t stat,
    output smac_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_CHECK,
        ST_MARK,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP1;
                end
            end
            ST_SETUP1: begin
                cmd.setup1 = 1'b1;
                state_next = ST_SETUP2;
            end
            ST_SETUP2: begin
                cmd.setup2 = 1'b1;
                if (stat.is_mark) begin
                    state_next = stat.mark_skip ? ST_RESP : ST_MARK;
                end else begin
                    state_next = stat.check_skip ? ST_RESP : ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check_step = 1'b1;
                if (stat.check_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_MARK: begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result word overwritten while still waiting");

    a_valid_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_RESP))
        else $error("result word raised outside the response state");
`endif

endmodule

// ----- rtl/core/shadow_memory_access_checker.sv -----
// ----------------------------------------------------------------------------
// Shadow memory access checker
// Checks accesses against a shadow store of one byte per 8-byte block and
// marks block-aligned ranges valid, partly valid or poisoned.
// ----------------------------------------------------------------------------
// Use: the s_ channel takes one command word (check or mark) with valid and
// ready, and the m_ channel returns exactly one result word per command.
// Configuration registers (region base, checking enable) are to be written
// on the cfg_ port while the block is idle; the block does not enforce it.
// After reset the block clears the shadow store, one entry per cycle;
// s_ready stays low during that pass.
// One item at a time is processed. A check that is skipped (checking off,
// outside the region, zero size) or a rejected or empty mark goes from setup
// straight to the response state. A check walks its shadow entries with one
// memory read per cycle and stops at the first violation or its last entry.
// A mark of N blocks makes one memory write per cycle.
// The result is held in an output register, so a new word is accepted while
// the previous result waits; if the receiver stalls, the next result waits in
// the response state until the output register is free.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker import smac_pkg::*; #(
    parameter int SHADOW_ENTRIES = DEF_SHADOW_ENTRIES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  smac_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output smac_out_t             m_data,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    smac_cmd_t  cmd;
    smac_stat_t stat;

    smac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    smac_datapath #(
        .SHADOW_ENTRIES (SHADOW_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_word   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (m_data)
    );

endmodule
